FILE: design/assert_macros.svh
// Assertion helpers, clocked on i_clk, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/cmaes_pkg.sv
package cmaes_pkg;

    localparam int IN_W  = 16;
    localparam int OUT_W = 16;
    localparam int CFG_W = 4;
    localparam logic [CFG_W-1:0] HALF_WIDTH_RESET = 4'd3;

    typedef struct packed {
        logic load;
        logic setup;
        logic acc;
        logic div_step;
        logic out_load;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic emit_needed;
        logic acc_last;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

FILE: design/cmaes_ctrl.sv
module cmaes_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  cmaes_pkg::t_stat i_stat,
    output cmaes_pkg::t_cmd  o_cmd
);
    import cmaes_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PLAN = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PLAN;
                end
            end
            S_PLAN: begin
                if (i_stat.emit_needed) begin
                    o_cmd.setup = 1'b1;
                    n_state     = S_ACC;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_stat.acc_last) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_PLAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: design/cmaes_dp.sv
module cmaes_dp #(
    parameter int MAX_HALF_WIDTH = 8,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cmaes_pkg::t_cmd              i_cmd,
    output cmaes_pkg::t_stat             o_stat,
    input  logic [cmaes_pkg::IN_W-1:0]   i_sample,
    input  logic                         i_last_in,
    input  logic                         i_cfg_valid,
    input  logic [cmaes_pkg::CFG_W-1:0]  i_cfg_half_width,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [cmaes_pkg::OUT_W-1:0]  o_smoothed,
    output logic                         o_last_out
);
    import cmaes_pkg::*;

    localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
    localparam int SW    = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int K_W   = $clog2(MAX_HALF_WIDTH + 1);
    localparam int CNT_W = $clog2(2 * MAX_HALF_WIDTH + 2);
    localparam int SUM_W = SW + IDX_W;
    localparam int DIV_W = $clog2(DEPTH + 1);
    localparam int BIT_W = $clog2(SUM_W + 1);

    logic [SW-1:0]    r_store [DEPTH];
    logic [CFG_W-1:0] r_hw;
    logic [K_W-1:0]   r_h;
    logic             r_last;
    logic [CNT_W-1:0] r_seen;
    logic [CNT_W-1:0] r_emit;
    logic [IDX_W-1:0] r_d;
    logic [DIV_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_div;
    logic [SUM_W-1:0] r_sum;
    logic [DIV_W-1:0] r_rem;
    logic [BIT_W-1:0] r_bits;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic             r_out_last;

    logic [K_W-1:0]   h_eff;
    logic [CNT_W-1:0] h_ext;
    logic [CNT_W-1:0] lag;
    logic [CNT_W-1:0] k_a;
    logic [CNT_W-1:0] k_sel;
    logic [CNT_W:0]   terms;
    logic [CNT_W:0]   right_edge;
    logic [DIV_W:0]   tmp;
    logic             ge;
    logic [CNT_W-1:0] n_seen;

    assign h_eff = (32'(r_hw) > MAX_HALF_WIDTH) ? K_W'(MAX_HALF_WIDTH) : K_W'(r_hw);
    assign h_ext = CNT_W'(r_h);
    assign lag   = r_seen - r_emit;
    assign k_a   = (r_emit < h_ext) ? r_emit : h_ext;
    assign k_sel = (r_last && (lag < k_a)) ? lag : k_a;
    assign terms = {k_sel, 1'b1};
    assign right_edge = {1'b0, r_emit} + {1'b0, h_ext};

    assign tmp = {r_rem, r_sum[SUM_W-1]};
    assign ge  = (tmp >= {1'b0, r_div});

    assign n_seen = r_seen + CNT_W'(1);

    assign o_stat.emit_needed = r_last ? (r_emit <= r_seen) : (right_edge <= {1'b0, r_seen});
    assign o_stat.acc_last    = (r_cnt == DIV_W'(1));
    assign o_stat.div_last    = (r_bits == BIT_W'(1));
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_smoothed  = r_out_data;
    assign o_last_out  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_store[0] <= i_sample[SW-1:0];
            for (int j = 1; j < DEPTH; j++) begin
                r_store[j] <= r_store[j-1];
            end
            r_last <= i_last_in;
            r_h    <= h_eff;
        end
        if (i_cmd.setup) begin
            r_d    <= IDX_W'(lag - k_sel);
            r_cnt  <= DIV_W'(terms);
            r_div  <= DIV_W'(terms);
            r_sum  <= '0;
            r_rem  <= '0;
            r_bits <= BIT_W'(SUM_W);
        end
        if (i_cmd.acc) begin
            r_sum <= r_sum + SUM_W'(r_store[r_d]);
            r_d   <= r_d + IDX_W'(1);
            r_cnt <= r_cnt - DIV_W'(1);
        end
        if (i_cmd.div_step) begin
            r_rem  <= ge ? DIV_W'(tmp - {1'b0, r_div}) : DIV_W'(tmp);
            r_sum  <= {r_sum[SUM_W-2:0], ge};
            r_bits <= r_bits - BIT_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_data <= OUT_W'(r_sum[SW-1:0]);
            r_out_last <= r_last && (r_emit == r_seen);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw        <= HALF_WIDTH_RESET;
            r_seen      <= '0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_hw <= i_cfg_half_width;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_emit      <= r_emit + CNT_W'(1);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                if (r_last) begin
                    r_seen <= '0;
                    r_emit <= '0;
                end else if (r_emit > CNT_W'(MAX_HALF_WIDTH)) begin
                    // slide both indexes down together
                    r_emit <= CNT_W'(MAX_HALF_WIDTH);
                    r_seen <= n_seen - (r_emit - CNT_W'(MAX_HALF_WIDTH));
                end else begin
                    r_seen <= n_seen;
                end
            end
        end
    end

endmodule

FILE: design/centered_moving_average_edge_shrink.sv
// Operation: each input beat is loaded into the sample shift line; for each result that
// it completes, the 2k+1 samples of its window are accumulated over the shift line, the
// sum is divided by 2k+1 in the radix-2 divider, and the quotient waits for a free output.
// Throughput: one input beat at a time; accumulator and divider are shared by all results.
// Reset: synchronous active low; clears counters, output valid, half width to 3.
`include "assert_macros.svh"

module centered_moving_average_edge_shrink #(
    parameter int MAX_HALF_WIDTH = 8,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [cmaes_pkg::IN_W-1:0]   i_sample,
    input  logic                         i_last_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [cmaes_pkg::OUT_W-1:0]  o_smoothed,
    output logic                         o_last_out,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [cmaes_pkg::CFG_W-1:0]  i_cfg_half_width
);
    import cmaes_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    cmaes_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cmaes_dp #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_sample         (i_sample),
        .i_last_in        (i_last_in),
        .i_cfg_valid      (i_cfg_valid && o_cfg_ready),
        .i_cfg_half_width (i_cfg_half_width),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_smoothed       (o_smoothed),
        .o_last_out       (o_last_out)
    );

    `ASSERT_NEXT(a_busy_after_beat, i_in_valid && o_in_ready, !o_in_ready)
    `ASSERT_IMPL(a_no_result_overwrite, cmd.out_load, !o_out_valid || i_out_ready)
    `ASSERT_ALWAYS(a_one_command, $onehot0(cmd))

endmodule

FILE: dv/cmaes_window_checker.sv
`timescale 1ns / 100ps

module cmaes_window_checker #(
    parameter int MAX_HALF = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [cmaes_pkg::IN_W-1:0]    i_sample,
    input  logic                          i_last_in,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [cmaes_pkg::OUT_W-1:0]   i_smoothed,
    input  logic                          i_last_out,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [cmaes_pkg::CFG_W-1:0]   i_cfg_half_width,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int DEPTH = 2 * MAX_HALF + 1;

    typedef struct packed {
        logic [cmaes_pkg::OUT_W-1:0] avg;
        logic                        is_last;
    } t_avg;

    logic [cmaes_pkg::IN_W-1:0]  line_q [DEPTH];
    logic [cmaes_pkg::CFG_W-1:0] half_cfg;
    int                          seen_cnt;
    int                          emit_cnt;
    int                          fails;
    t_avg                        avg_q [$];

    function automatic logic [cmaes_pkg::OUT_W-1:0] window_mean(int lag, int k);
        logic [31:0] acc;
        acc = '0;
        for (int d = lag - k; d <= lag + k; d++) begin
            if (d < DEPTH) begin
                acc += 32'(line_q[d]);
            end
        end
        return cmaes_pkg::OUT_W'(acc / 32'(2 * k + 1));
    endfunction

    task automatic push_avg(int lag, int k, logic fin);
        t_avg r;
        r.avg     = window_mean(lag, k);
        r.is_last = fin;
        avg_q     = {avg_q, r};
    endtask

    // one input beat: shift it in and queue every window that it completes
    task automatic take_sample(logic [cmaes_pkg::IN_W-1:0] s, logic fin);
        int h;
        int newest;
        int k;
        h      = (int'(half_cfg) > MAX_HALF) ? MAX_HALF : int'(half_cfg);
        newest = seen_cnt;
        for (int j = DEPTH - 1; j > 0; j--) begin
            line_q[j] = line_q[j-1];
        end
        line_q[0] = s;
        if (fin) begin
            for (int i = emit_cnt; i <= newest; i++) begin
                k = (i < newest - i) ? i : newest - i;
                k = (k < h) ? k : h;
                push_avg(newest - i, k, i == newest);
            end
            seen_cnt = 0;
            emit_cnt = 0;
        end else begin
            while (emit_cnt + h <= newest) begin
                k = (emit_cnt < h) ? emit_cnt : h;
                push_avg(newest - emit_cnt, k, 1'b0);
                emit_cnt++;
            end
            seen_cnt = newest + 1;
            if (emit_cnt > MAX_HALF) begin
                seen_cnt -= emit_cnt - MAX_HALF;
                emit_cnt  = MAX_HALF;
            end
        end
    endtask

    always @(posedge i_clk) begin : mon
        t_avg want;
        if (!i_rst_n) begin
            for (int j = 0; j < DEPTH; j++) begin
                line_q[j] = '0;
            end
            half_cfg = cmaes_pkg::HALF_WIDTH_RESET;
            seen_cnt = 0;
            emit_cnt = 0;
            fails    = 0;
            avg_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                half_cfg = i_cfg_half_width;
            end
            if (i_in_valid && i_in_ready) begin
                take_sample(i_sample, i_last_in);
            end
            if (i_out_valid && i_out_ready) begin
                if (avg_q.size() == 0) begin
                    if (fails < 10) begin
                        $display("%0t: unexpected output beat smoothed %h last %0d",
                                 $time, i_smoothed, i_last_out);
                    end
                    fails++;
                end else begin
                    want = avg_q.pop_front();
                    if (want.avg !== i_smoothed || want.is_last !== i_last_out) begin
                        if (fails < 10) begin
                            $display("%0t: mismatch expected smoothed %h last %0d, got %h %0d",
                                     $time, want.avg, want.is_last, i_smoothed, i_last_out);
                        end
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= avg_q.size();
    end

endmodule

FILE: dv/tb_centered_moving_average_edge_shrink.sv
`timescale 1ns / 100ps

module tb_centered_moving_average_edge_shrink;

    localparam int MAX_HALF    = 8;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE      = 100;
    localparam int CYCLE_LIMIT = 400000;

    logic                         i_clk;
    logic                         i_rst_n     = 1'b0;
    logic                         in_valid    = 1'b0;
    logic [cmaes_pkg::IN_W-1:0]   sample      = '0;
    logic                         last_in     = 1'b0;
    logic                         out_ready   = 1'b0;
    logic                         cfg_valid   = 1'b0;
    logic [cmaes_pkg::CFG_W-1:0]  cfg_half    = '0;
    logic                         o_in_ready;
    logic                         o_out_valid;
    logic [cmaes_pkg::OUT_W-1:0]  o_smoothed;
    logic                         o_last_out;
    logic                         o_cfg_ready;
    int                           fail_count;
    int                           pending;
    int                           send_idle_pct = 30;
    int                           recv_idle_pct = 50;
    logic                         hold_req      = 1'b0;
    int                           hold_left     = 0;
    int                           cycle_cnt     = 0;

    centered_moving_average_edge_shrink #(
        .MAX_HALF_WIDTH (MAX_HALF),
        .SAMPLE_BITS    (16)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_sample         (sample),
        .i_last_in        (last_in),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_smoothed       (o_smoothed),
        .o_last_out       (o_last_out),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_half_width (cfg_half)
    );

    cmaes_window_checker #(
        .MAX_HALF (MAX_HALF)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (o_in_ready),
        .i_sample         (sample),
        .i_last_in        (last_in),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .i_smoothed       (o_smoothed),
        .i_last_out       (o_last_out),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_half_width (cfg_half),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // output side: random backpressure plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_beat(input logic [cmaes_pkg::IN_W-1:0] s, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        last_in  <= fin;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic write_half(input logic [cmaes_pkg::CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_half  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending until every queued average is out and the block has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int                          sent;
        int                          seq_len;
        int                          split;
        logic [cmaes_pkg::IN_W-1:0]  smp;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single-sample sequences, short sequence, extremes
        write_half(4'd3);
        send_beat(16'hFFFF, 1'b1);
        send_beat(16'h0000, 1'b1);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'h0001, 1'b0);
        send_beat(16'hFFFF, 1'b1);
        drain();
        // zero half width: pass-through
        write_half(4'd0);
        send_beat(16'h8000, 1'b0);
        send_beat(16'h7FFF, 1'b1);
        drain();
        // oversized half width clamps to the max
        write_half(4'd15);
        for (int j = 0; j < 10; j++) begin
            send_beat((j % 2 == 0) ? 16'hFFFF : 16'h0000, j == 9);
        end
        drain();
        // half width shrinks mid-sequence: held outputs flush on the next beat
        write_half(4'd8);
        for (int j = 0; j < 5; j++) begin
            send_beat(16'(16'h1357 * (j + 1)), 1'b0);
        end
        drain();
        write_half(4'd2);
        send_beat(16'hA5A5, 1'b0);
        send_beat(16'h5A5A, 1'b1);
        drain();

        for (int m = 0; m < 3; m++) begin
            send_idle_pct = (m == 0) ? 30 : (m == 1) ? 50 : 0;
            recv_idle_pct = (m == 0) ? 50 : (m == 1) ? 30 : 0;
            if (m == 2) begin
                hold_req = 1'b1;
            end
            sent = 0;
            while (sent < 75) begin
                seq_len = ($urandom_range(7) == 0) ? $urandom_range(17, 40)
                                                   : $urandom_range(1, 12);
                split = (seq_len > 1 && $urandom_range(5) == 0)
                        ? $urandom_range(1, seq_len - 1) : 0;
                if ($urandom_range(2) == 0) begin
                    drain();
                    write_half(4'($urandom_range(15)));
                end
                for (int j = 0; j < seq_len; j++) begin
                    if (j != 0 && j == split) begin
                        drain();
                        write_half(4'($urandom_range(15)));
                    end
                    case ($urandom_range(5))
                        0:       smp = '0;
                        1:       smp = '1;
                        default: smp = 16'($urandom);
                    endcase
                    send_beat(smp, j == seq_len - 1);
                end
                sent += seq_len;
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: centered_moving_average_edge_shrink.f
+incdir+design
design/cmaes_pkg.sv
design/cmaes_ctrl.sv
design/cmaes_dp.sv
design/centered_moving_average_edge_shrink.sv
dv/cmaes_window_checker.sv
dv/tb_centered_moving_average_edge_shrink.sv
